// ----- rtl/plmd_pkg.sv -----
`timescale 1ns / 1ps
package plmd_pkg;

	localparam int COEF_W = 8;

	localparam logic [1:0] REG_DEGREE = 2'd0;
	localparam logic [1:0] REG_LEAD   = 2'd1;
	localparam logic [1:0] REG_LOWER  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_APPLY,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic              shift;
		logic [COEF_W-1:0] q;
	} cell_ctl_t;

endpackage

// ----- rtl/poly_long_divider.sv -----
`timescale 1ns / 1ps
// Item that only fills the window: accepted in the idle state, no result.
// Item on a full window: quotient in the output register after the shared divider's
// divide, quotient capture and update step; the divide is skipped when divisor_lead is 0.
// Final item: remainder coefficients leave the cell row one per cycle unless output stalls.
// A new item is taken only when idle, after the previous item's divide, output and flush.
// Reset (arst_n low, async): state, count and config registers reset; window cells are not reset.
module poly_long_divider #(
	parameter int MAX_DIVISOR_DEGREE = 7
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [plmd_pkg::COEF_W-1:0]   coef_in,
	input  logic                                 final_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [plmd_pkg::COEF_W-1:0]   value,
	output logic                                 is_remainder,
	output logic                                 final_out,
	output logic                                 zero_lead,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [plmd_pkg::COEF_W*MAX_DIVISOR_DEGREE-1:0] cfg_data
);
	import plmd_pkg::*;

	localparam int MAXD    = MAX_DIVISOR_DEGREE;
	localparam int LOWER_W = COEF_W * MAXD;
	localparam int EXT_W   = COEF_W * 8;

	state_t state_q, state_d;

	logic [2:0]          deg_q;
	logic [COEF_W-1:0]   lead_q;
	logic [LOWER_W-1:0]  lower_q;
	logic [EXT_W-1:0]    lower_ext;
	logic [2:0]          d_eff;
	logic                zl;

	logic [2:0]          count_q;
	logic [COEF_W-1:0]   c_q;
	logic                fin_q;
	logic [COEF_W-1:0]   q_q;

	logic                out_valid_q;
	logic [COEF_W-1:0]   value_q;
	logic                is_rem_q;
	logic                final_q;
	logic                zl_q;

	logic                out_free;
	logic                accept;
	logic                append;
	logic                div_start;
	logic                step;
	logic                flush;
	logic                push;
	logic                div_done;
	logic [COEF_W-1:0]   div_q;
	cell_ctl_t           ctl;
	logic [COEF_W-1:0]   w [MAXD];

	assign lower_ext = {(EXT_W-LOWER_W)'(0), lower_q};
	assign d_eff = (deg_q == 3'd0) ? 3'd1 :
		((deg_q > 3'(MAXD)) ? 3'(MAXD) : deg_q);
	assign zl = (lead_q == '0);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (count_q == d_eff) begin
						state_d = zl ? S_APPLY : S_DIV;
					end else if (final_in) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_DIV: begin
				if (div_done) state_d = S_APPLY;
			end
			S_APPLY: begin
				if (out_free) state_d = fin_q ? S_FLUSH : S_IDLE;
			end
			S_FLUSH: begin
				if (out_free && count_q == 3'd1) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		accept    = in_valid && in_ready;
		append    = accept && (count_q != d_eff);
		div_start = accept && (count_q == d_eff) && !zl;
		step      = (state_q == S_APPLY) && out_free;
		flush     = (state_q == S_FLUSH) && out_free;
		push      = step || flush;
		ctl.shift = push;
		ctl.q     = flush ? '0 : q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			deg_q       <= 3'd1;
			lead_q      <= COEF_W'(1);
			lower_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_DEGREE: begin
						deg_q   <= cfg_data[2:0];
						count_q <= '0;
					end
					REG_LEAD:  lead_q  <= cfg_data[COEF_W-1:0];
					REG_LOWER: lower_q <= cfg_data;
					default: ;
				endcase
			end
			if (append) begin
				count_q <= count_q + 3'd1;
			end else if (flush) begin
				count_q <= count_q - 3'd1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q   <= coef_in;
			fin_q <= final_in;
			q_q   <= '0;
		end else if (div_done) begin
			q_q <= div_q;
		end
		if (push) begin
			value_q  <= step ? q_q : w[0];
			is_rem_q <= flush;
			final_q  <= flush && (count_q == 3'd1);
			zl_q     <= zl;
		end
	end

	plmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (w[0]),
		.divisor  (lead_q),
		.done     (div_done),
		.quotient (div_q)
	);

	for (genvar k = 0; k < MAXD; k++) begin : g_cell
		logic [2:0]        bidx;
		logic [COEF_W-1:0] b_sel;
		logic [COEF_W-1:0] nbr;

		assign bidx  = d_eff - 3'd1 - 3'(k);
		assign b_sel = lower_ext[bidx*COEF_W +: COEF_W];
		if (k == MAXD - 1) begin : g_end
			assign nbr = c_q;
		end else begin : g_mid
			assign nbr = (3'(k) == d_eff - 3'd1) ? c_q : w[k+1];
		end

		plmd_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load      (append && (count_q == 3'(k))),
			.load_data (coef_in),
			.nbr       (nbr),
			.b         (b_sel),
			.w         (w[k])
		);
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign is_remainder = is_rem_q;
	assign final_out    = final_q;
	assign zero_lead    = zl_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= d_eff)
		else $error("pending count above divisor degree");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (count_q != 3'd0))
		else $error("flush with empty window");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(flush && count_q == 3'd1) |=> (count_q == 3'd0 && state_q == S_IDLE))
		else $error("flush did not end cleanly");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !push)
		else $error("held result overwritten");

endmodule

// ----- rtl/plmd_cell.sv -----
`timescale 1ns / 1ps
module plmd_cell (
	input  logic                      clk,
	input  plmd_pkg::cell_ctl_t       ctl,
	input  logic                      load,
	input  logic [plmd_pkg::COEF_W-1:0] load_data,
	input  logic [plmd_pkg::COEF_W-1:0] nbr,
	input  logic [plmd_pkg::COEF_W-1:0] b,
	output logic [plmd_pkg::COEF_W-1:0] w
);
	import plmd_pkg::*;

	logic [2*COEF_W-1:0] prod;
	logic [COEF_W-1:0]   w_q;

	assign prod = (2*COEF_W)'(ctl.q) * (2*COEF_W)'(b);
	assign w = w_q;

	always_ff @(posedge clk) begin
		if (load) begin
			w_q <= load_data;
		end else if (ctl.shift) begin
			w_q <= nbr - prod[COEF_W-1:0];
		end
	end

endmodule

// ----- rtl/plmd_div.sv -----
`timescale 1ns / 1ps
module plmd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plmd_pkg::COEF_W-1:0] dividend,
	input  logic [plmd_pkg::COEF_W-1:0] divisor,
	output logic                        done,
	output logic [plmd_pkg::COEF_W-1:0] quotient
);
	import plmd_pkg::*;

	logic [COEF_W-1:0] num_q;
	logic [COEF_W-1:0] den_q;
	logic [COEF_W-1:0] rem_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [2:0]        cnt_q;
	logic [COEF_W:0]   trial;
	logic [COEF_W:0]   shifted;

	assign shifted  = {rem_q, num_q[COEF_W-1]};
	assign trial    = shifted - {1'b0, den_q};
	assign done     = done_q;
	assign quotient = neg_q ? (~num_q + 1'b1) : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[COEF_W-1] ? (~dividend + 1'b1) : dividend;
			den_q <= divisor[COEF_W-1] ? (~divisor + 1'b1) : divisor;
			rem_q <= '0;
			neg_q <= dividend[COEF_W-1] ^ divisor[COEF_W-1];
		end else if (busy_q) begin
			if (!trial[COEF_W]) begin
				rem_q <= trial[COEF_W-1:0];
				num_q <= {num_q[COEF_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[COEF_W-1:0];
				num_q <= {num_q[COEF_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- verif/poly_long_divider_check.sv -----
`timescale 1ns / 1ps
module poly_long_divider_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  coef_in,
	input  logic        final_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  value,
	input  logic        is_remainder,
	input  logic        final_out,
	input  logic        zero_lead,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data,
	output int          fails,
	output int          outstanding,
	output int          results_seen,
	output int          rem_seen
);
	import plmd_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       rem;
		logic       fin;
		logic       zl;
	} coef_result_t;

	logic [2:0]   div_degree = 3'd1;
	logic [7:0]   div_lead = 8'd1;
	logic [55:0]  div_lower = '0;
	byte          window [7];
	int           fill = 0;
	coef_result_t expected_q [$];
	coef_result_t got, want;

	function automatic int lower_coef(int j);
		return int'(byte'(div_lower[8*j +: 8]));
	endfunction

	task automatic clear_window();
		fill = 0;
		foreach (window[i]) window[i] = 0;
	endtask

	// One dividend coefficient through the long-division window.
	task automatic divide_step(input byte coef, input bit last);
		int  d;
		byte lead, q;
		bit  zl;
		d = (div_degree == 3'd0) ? 1 : int'(div_degree);
		lead = byte'(div_lead);
		zl = (lead == 0);
		if (fill == d) begin
			q = zl ? byte'(0) : byte'(int'(window[0]) / int'(lead));
			expected_q.push_back({q, 1'b0, 1'b0, zl});
			for (int k = 1; k < d; k++)
				window[k-1] = byte'(int'(window[k]) - int'(q) * lower_coef(d - k));
			window[d-1] = byte'(int'(coef) - int'(q) * lower_coef(0));
		end else begin
			window[fill] = coef;
			fill++;
		end
		if (last) begin
			for (int k = 0; k < fill; k++)
				expected_q.push_back({window[k], 1'b1, (k + 1 == fill), zl});
			clear_window();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_degree = 3'd1;
			div_lead = 8'd1;
			div_lower = '0;
			clear_window();
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEGREE: begin
						div_degree = cfg_data[2:0];
						clear_window();
					end
					REG_LEAD: div_lead = cfg_data[7:0];
					REG_LOWER: div_lower = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {value, is_remainder, final_out, zero_lead};
				results_seen++;
				if (is_remainder === 1'b1) rem_seen++;
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected: value %0d rem %b fin %b zl %b",
						$time, $signed(got.value), got.rem, got.fin, got.zl);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected value %0d rem %b fin %b zl %b, got value %0d rem %b fin %b zl %b",
							$time, $signed(want.value), want.rem, want.fin, want.zl,
							$signed(got.value), got.rem, got.fin, got.zl);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) divide_step(byte'(coef_in), final_in);
			outstanding = expected_q.size();
		end
	end

endmodule

// ----- verif/poly_long_divider_test.sv -----
`timescale 1ns / 1ps
module poly_long_divider_test;
	import plmd_pkg::*;

	localparam int SETTLE = 16;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 38;
	localparam time LIMIT = 400_000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [COEF_W-1:0] coef_in = '0;
	logic                     final_in = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [COEF_W-1:0] value;
	logic                     is_remainder;
	logic                     final_out;
	logic                     zero_lead;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_index = REG_DEGREE;
	logic [55:0]              cfg_data = '0;

	int fails, outstanding, results_seen, rem_seen;
	int tx_idle = 0;
	int rx_stall = 0;
	int items_sent = 0;
	int divisions = 0;
	int reg_writes = 0;
	int cur_deg = 1;

	poly_long_divider DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .coef_in(coef_in), .final_in(final_in),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.is_remainder(is_remainder), .final_out(final_out), .zero_lead(zero_lead),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	poly_long_divider_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .coef_in(coef_in), .final_in(final_in),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.is_remainder(is_remainder), .final_out(final_out), .zero_lead(zero_lead),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .outstanding(outstanding),
		.results_seen(results_seen), .rem_seen(rem_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall);

	initial begin
		#(LIMIT);
		$display("timeout with %0d results outstanding", outstanding);
		$display("FAILURE");
		$finish;
	end

	task automatic send_coef(input byte c, input bit last);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coef_in <= c;
		final_in <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (last) divisions++;
	endtask

	// block is idle once nothing is owed and the divider has had time to settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [55:0] data);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (idx == REG_DEGREE) cur_deg = (data[2:0] == 3'd0) ? 1 : int'(data[2:0]);
	endtask

	initial begin
		int          len, cut, sent;
		logic [7:0]  ld;
		logic [55:0] lw;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: mixed-sign divisor, field extremes
		write_reg(REG_DEGREE, 56'd2);
		write_reg(REG_LEAD, 56'h03);
		write_reg(REG_LOWER, 56'hFE05);
		send_coef(127, 1'b0);
		send_coef(-128, 1'b0);
		send_coef(0, 1'b0);
		send_coef(5, 1'b1);

		// -128 / -1 wraps
		wait_drain();
		write_reg(REG_DEGREE, 56'd1);
		write_reg(REG_LEAD, 56'hFF);
		write_reg(REG_LOWER, '1);
		send_coef(-128, 1'b0);
		send_coef(-128, 1'b1);

		// zero lead
		wait_drain();
		write_reg(REG_LEAD, 56'h00);
		send_coef(7, 1'b0);
		send_coef(-3, 1'b0);
		send_coef(9, 1'b1);

		// degree 0 acts as 1
		wait_drain();
		write_reg(REG_DEGREE, 56'd0);
		write_reg(REG_LEAD, 56'h80);
		send_coef(100, 1'b0);
		send_coef(-1, 1'b1);

		// dividend shorter than the divisor
		wait_drain();
		write_reg(REG_DEGREE, 56'd7);
		write_reg(REG_LEAD, 56'h7F);
		send_coef(1, 1'b0);
		send_coef(2, 1'b1);
		send_coef(-5, 1'b1);

		// degree rewrite drops a division in progress
		wait_drain();
		write_reg(REG_DEGREE, 56'd3);
		write_reg(REG_LEAD, 56'h02);
		send_coef(4, 1'b0);
		send_coef(5, 1'b0);
		send_coef(6, 1'b0);
		send_coef(7, 1'b0);
		wait_drain();
		write_reg(REG_DEGREE, 56'd2);
		send_coef(1, 1'b0);
		send_coef(1, 1'b0);
		send_coef(1, 1'b1);

		// lead and lower divisor changed mid-division
		wait_drain();
		write_reg(REG_LOWER, 56'h0301);
		send_coef(10, 1'b0);
		send_coef(20, 1'b0);
		send_coef(30, 1'b0);
		wait_drain();
		write_reg(REG_LEAD, 56'hFD);
		write_reg(REG_LOWER, 56'h7F80);
		send_coef(40, 1'b0);
		send_coef(50, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin tx_idle = 0;  rx_stall = 0;  end
				1: begin tx_idle = 76; rx_stall = 0;  end
				2: begin tx_idle = 0;  rx_stall = 76; end
				default: begin tx_idle = 15; rx_stall = 15; end
			endcase
			wait_drain();
			case ($urandom_range(9))
				0: ld = 8'h00;
				1: ld = 8'h80;
				2: ld = 8'h7F;
				3: ld = 8'hFF;
				4: ld = 8'h01;
				default: ld = 8'($urandom);
			endcase
			case ($urandom_range(5))
				0: lw = '0;
				1: lw = '1;
				default: lw = 56'({$urandom, $urandom});
			endcase
			case (p)
				0: write_reg(REG_DEGREE, 56'd7);
				1: write_reg(REG_DEGREE, 56'd1);
				default: write_reg(REG_DEGREE, 56'($urandom_range(7)));
			endcase
			write_reg(REG_LEAD, {48'd0, ld});
			write_reg(REG_LOWER, lw);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(16, 30)
					: $urandom_range(1, cur_deg + 5);
				if ($urandom_range(9) == 0) begin
					// cut short, then a register rewrite while idle
					cut = $urandom_range(1, len);
					for (int i = 0; i < cut; i++) send_coef(byte'($urandom), 1'b0);
					wait_drain();
					if ($urandom_range(1)) write_reg(REG_DEGREE, 56'($urandom_range(7)));
					else write_reg(REG_LEAD, {48'd0, 8'($urandom)});
					sent += cut;
				end else begin
					for (int i = 0; i < len; i++) send_coef(byte'($urandom), i == len - 1);
					sent += len;
				end
			end
		end
		wait_drain();

		$display("Sent %0d coefficients in %0d divisions with %0d register writes,",
			items_sent, divisions, reg_writes);
		$display("four idling mixes; checked %0d results, %0d remainder, %0d mismatches.",
			results_seen, rem_seen, fails);
		if (fails == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
